FILE: hdl/gpb_pkg.sv
// Shared types and codes for the GPIO port bank controller.
`timescale 1ns / 1ps

package gpb_pkg;

   localparam int unsigned PORT_W = 4;
   localparam int unsigned PIN_W  = 5;
   localparam int unsigned MASK_W = 16;
   localparam int unsigned CLK_W  = 8;

   // Operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CONFIG = 2'd2;

   // Pin mode codes
   localparam logic [1:0] MODE_OUTPUT = 2'd1;
   localparam logic [1:0] MODE_ALT    = 2'd2;
   localparam logic [1:0] MODE_ANALOG = 2'd3;

   // Pull codes
   localparam logic [1:0] PULL_UP   = 2'd1;
   localparam logic [1:0] PULL_DOWN = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [PORT_W-1:0] port;
      logic [MASK_W-1:0] mask;
      logic [MASK_W-1:0] value;
      logic [PIN_W-1:0]  pin;
      logic [1:0]        mode;
      logic [3:0]        alt_func;
      logic              open_drain;
      logic [1:0]        speed;
      logic [1:0]        pull;
      logic [MASK_W-1:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [MASK_W-1:0] read_data;
      logic [MASK_W-1:0] drive_level;
      logic [MASK_W-1:0] output_enable;
      logic [MASK_W-1:0] alt_enable;
      logic [MASK_W-1:0] analog_enable;
      logic [MASK_W-1:0] open_drain_mask;
      logic [MASK_W-1:0] pullup_mask;
      logic [MASK_W-1:0] pulldown_mask;
      logic [31:0]       speed_select;
      logic [63:0]       alt_select;
      logic [CLK_W-1:0]  clock_enabled;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

endpackage

FILE: hdl/gpio_port_bank_controller.sv
// Top level of the GPIO port bank controller.
`timescale 1ns / 1ps
//
//  channel   ports                             moves
//  -------   --------------------------------  ---------------------------
//  request   req_valid, req_ready, req_data    one operation item in
//  result    rsp_valid, rsp_ready, rsp_data    one result item per request
//
// An item is captured into the item register in ST_IDLE; in ST_EXEC the
// read-modify-write of the addressed port's state loads the result register.
// The next item is taken while a result waits; its execute cycle holds until
// the result register is free or being emptied.
// Synchronous reset clears all pin state and the clock enables at once.

module gpio_port_bank_controller #(
   parameter int NUM_PORTS     = 8,
   parameter int PINS_PER_PORT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gpb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gpb_pkg::rsp_type rsp_data
);

   gpb_pkg::cmd_type cmd;

   gpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   gpb_datapath #(
      .NUM_PORTS     (NUM_PORTS),
      .PINS_PER_PORT (PINS_PER_PORT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hdl/gpb_ctrl.sv
// Controller: sequences item capture, execution and the result register.
`timescale 1ns / 1ps

module gpb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gpb_pkg::cmd_type  cmd
);

   gpb_pkg::ctrl_state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic fire;

   // execute once the result register is free or being emptied
   assign fire      = (state_ff == gpb_pkg::ST_EXEC) && (!out_valid_ff || rsp_ready);
   assign req_ready = (state_ff == gpb_pkg::ST_IDLE) && !reset;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd.load    = req_valid && req_ready;
      cmd.execute = fire;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gpb_pkg::ST_IDLE: begin
            if (req_valid && req_ready) state_in = gpb_pkg::ST_EXEC;
         end
         gpb_pkg::ST_EXEC: begin
            if (fire) state_in = gpb_pkg::ST_IDLE;
         end
         default: state_in = gpb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpb_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: hdl/gpb_datapath.sv
// Datapath: item register, per-port pin state, decode and result register.
`timescale 1ns / 1ps

module gpb_datapath #(
   parameter int NUM_PORTS     = 8,
   parameter int PINS_PER_PORT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  gpb_pkg::cmd_type  cmd,
   input  gpb_pkg::req_type  req_data,
   output gpb_pkg::rsp_type  rsp_data
);

   localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   gpb_pkg::req_type item_ff;
   gpb_pkg::rsp_type rsp_ff, rsp_in;

   logic [1:0]               mode_ff  [NUM_PORTS][PINS_PER_PORT];
   logic [1:0]               speed_ff [NUM_PORTS][PINS_PER_PORT];
   logic [1:0]               pull_ff  [NUM_PORTS][PINS_PER_PORT];
   logic [3:0]               alt_ff   [NUM_PORTS][PINS_PER_PORT];
   logic [PINS_PER_PORT-1:0] od_ff    [NUM_PORTS];
   logic [PINS_PER_PORT-1:0] latch_ff [NUM_PORTS];
   logic [gpb_pkg::CLK_W-1:0] clk_en_ff, clk_en_in;

   logic [1:0]               mode_in  [PINS_PER_PORT];
   logic [1:0]               speed_in [PINS_PER_PORT];
   logic [1:0]               pull_in  [PINS_PER_PORT];
   logic [3:0]               alt_in   [PINS_PER_PORT];
   logic [PINS_PER_PORT-1:0] od_in, latch_in, pin_sel;

   logic [PORT_IDX_W-1:0] idx;
   logic port_ok, pin_ok, wr_hit, rd_hit, cfg_hit;

   assign idx     = item_ff.port[PORT_IDX_W-1:0];
   assign port_ok = {1'b0, item_ff.port} < (gpb_pkg::PORT_W + 1)'(NUM_PORTS);
   assign pin_ok  = item_ff.pin < gpb_pkg::PIN_W'(PINS_PER_PORT);
   assign wr_hit  = port_ok && (item_ff.op == gpb_pkg::OP_WRITE);
   assign rd_hit  = port_ok && (item_ff.op == gpb_pkg::OP_READ);
   assign cfg_hit = port_ok && (item_ff.op == gpb_pkg::OP_CONFIG) && pin_ok;

   // addressed port after the step
   always_comb begin
      for (int n = 0; n < PINS_PER_PORT; n++) begin
         pin_sel[n]  = cfg_hit && (item_ff.pin == gpb_pkg::PIN_W'(n));
         latch_in[n] = (wr_hit && item_ff.mask[n]) ? item_ff.value[n] : latch_ff[idx][n];
         mode_in[n]  = pin_sel[n] ? item_ff.mode       : mode_ff[idx][n];
         speed_in[n] = pin_sel[n] ? item_ff.speed      : speed_ff[idx][n];
         pull_in[n]  = pin_sel[n] ? item_ff.pull       : pull_ff[idx][n];
         alt_in[n]   = pin_sel[n] ? item_ff.alt_func   : alt_ff[idx][n];
         od_in[n]    = pin_sel[n] ? item_ff.open_drain : od_ff[idx][n];
      end
      for (int k = 0; k < gpb_pkg::CLK_W; k++) begin
         clk_en_in[k] = clk_en_ff[k] || (cfg_hit && (item_ff.port == gpb_pkg::PORT_W'(k)));
      end
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = !(wr_hit || rd_hit || cfg_hit);
      rsp_in.clock_enabled = clk_en_in;
      if (port_ok) begin
         for (int n = 0; n < PINS_PER_PORT; n++) begin
            rsp_in.read_data[n]       = rd_hit && item_ff.pin_levels[n];
            rsp_in.drive_level[n]     = latch_in[n];
            rsp_in.output_enable[n]   = (mode_in[n] == gpb_pkg::MODE_OUTPUT);
            rsp_in.alt_enable[n]      = (mode_in[n] == gpb_pkg::MODE_ALT);
            rsp_in.analog_enable[n]   = (mode_in[n] == gpb_pkg::MODE_ANALOG);
            rsp_in.open_drain_mask[n] = od_in[n];
            rsp_in.pullup_mask[n]     = (pull_in[n] == gpb_pkg::PULL_UP);
            rsp_in.pulldown_mask[n]   = (pull_in[n] == gpb_pkg::PULL_DOWN);
            rsp_in.speed_select[2*n +: 2] = speed_in[n];
            rsp_in.alt_select[4*n +: 4]   = alt_in[n];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            od_ff[p]    <= '0;
            latch_ff[p] <= '0;
            for (int n = 0; n < PINS_PER_PORT; n++) begin
               mode_ff[p][n]  <= '0;
               speed_ff[p][n] <= '0;
               pull_ff[p][n]  <= '0;
               alt_ff[p][n]   <= '0;
            end
         end
         clk_en_ff <= '0;
      end else if (cmd.execute) begin
         if (wr_hit) begin
            latch_ff[idx] <= latch_in;
         end
         if (cfg_hit) begin
            mode_ff[idx]  <= mode_in;
            speed_ff[idx] <= speed_in;
            pull_ff[idx]  <= pull_in;
            alt_ff[idx]   <= alt_in;
            od_ff[idx]    <= od_in;
         end
         clk_en_ff <= clk_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/gpb_checker.sv
// Port-level checks for the GPIO port bank controller, bound to the top level.
`timescale 1ns / 1ps

module gpb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input gpb_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gpb_pkg::rsp_type rsp_data
);

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a new result follows an accepted item, captured and then executed
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching item");

   // one item is worked at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken during execution");

endmodule

bind gpio_port_bank_controller gpb_checker u_gpb_checker (.*);

FILE: test/gpb_result_checker.sv
// Result checker for the GPIO port bank controller: predicts and compares each result item.
`timescale 1ns / 1ps

module gpb_result_checker #(
   parameter int NUM_PORTS     = 8,
   parameter int PINS_PER_PORT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  gpb_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  gpb_pkg::rsp_type rsp_data,
   output int unsigned      fail_count,
   output int unsigned      outstanding,
   output int unsigned      results_checked
);

   localparam int unsigned REPORT_LIMIT = 10;

   // Per-port pin state as the block should hold it
   logic [2*gpb_pkg::MASK_W-1:0] mode_word  [NUM_PORTS];
   logic [gpb_pkg::MASK_W-1:0]   od_word    [NUM_PORTS];
   logic [2*gpb_pkg::MASK_W-1:0] speed_word [NUM_PORTS];
   logic [2*gpb_pkg::MASK_W-1:0] pull_word  [NUM_PORTS];
   logic [4*gpb_pkg::MASK_W-1:0] alt_word   [NUM_PORTS];
   logic [gpb_pkg::MASK_W-1:0]   out_latch  [NUM_PORTS];
   logic [gpb_pkg::CLK_W-1:0]    clk_on;

   gpb_pkg::rsp_type expected_results[$];

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   // Pins whose two-bit field in the word carries the given code
   function automatic logic [gpb_pkg::MASK_W-1:0] pins_coded(
         input logic [2*gpb_pkg::MASK_W-1:0] word, input logic [1:0] code);
      logic [gpb_pkg::MASK_W-1:0] hits;
      hits = '0;
      for (int n = 0; n < PINS_PER_PORT; n++)
         hits[n] = (word[2*n +: 2] == code);
      return hits;
   endfunction

   task automatic predict_port_result(input gpb_pkg::req_type r, output gpb_pkg::rsp_type want);
      int unsigned p;
      int unsigned n;
      logic        done;
      want = '0;
      done = 1'b0;
      if (r.port < NUM_PORTS) begin
         p = r.port;
         n = r.pin;
         unique case (r.op)
            gpb_pkg::OP_WRITE: begin
               out_latch[p] = (out_latch[p] | (r.mask & r.value)) & ~(r.mask & ~r.value);
               done = 1'b1;
            end
            gpb_pkg::OP_READ: begin
               want.read_data = r.pin_levels;
               done = 1'b1;
            end
            gpb_pkg::OP_CONFIG: begin
               if (n < PINS_PER_PORT) begin
                  clk_on[p]            = 1'b1;
                  mode_word[p][2*n +: 2]  = r.mode;
                  od_word[p][n]           = r.open_drain;
                  speed_word[p][2*n +: 2] = r.speed;
                  pull_word[p][2*n +: 2]  = r.pull;
                  alt_word[p][4*n +: 4]   = r.alt_func;
                  done = 1'b1;
               end
            end
            default: ;
         endcase
         want.drive_level     = out_latch[p];
         want.output_enable   = pins_coded(mode_word[p], gpb_pkg::MODE_OUTPUT);
         want.alt_enable      = pins_coded(mode_word[p], gpb_pkg::MODE_ALT);
         want.analog_enable   = pins_coded(mode_word[p], gpb_pkg::MODE_ANALOG);
         want.open_drain_mask = od_word[p];
         want.pullup_mask     = pins_coded(pull_word[p], gpb_pkg::PULL_UP);
         want.pulldown_mask   = pins_coded(pull_word[p], gpb_pkg::PULL_DOWN);
         want.speed_select    = speed_word[p];
         want.alt_select      = alt_word[p];
      end
      want.status        = ~done;
      want.clock_enabled = clk_on;
   endtask

   task automatic record_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (fail_count < REPORT_LIMIT)
         $display("mismatch at result %0d, %s: expected %0h, got %0h",
                  results_checked, what, want, got);
      fail_count++;
   endtask

   task automatic compare_result(input gpb_pkg::rsp_type want, input gpb_pkg::rsp_type got);
      if (got.status !== want.status)
         record_mismatch("status", want.status, got.status);
      if (got.read_data !== want.read_data)
         record_mismatch("read_data", want.read_data, got.read_data);
      if (got.drive_level !== want.drive_level)
         record_mismatch("drive_level", want.drive_level, got.drive_level);
      if (got.output_enable !== want.output_enable)
         record_mismatch("output_enable", want.output_enable, got.output_enable);
      if (got.alt_enable !== want.alt_enable)
         record_mismatch("alt_enable", want.alt_enable, got.alt_enable);
      if (got.analog_enable !== want.analog_enable)
         record_mismatch("analog_enable", want.analog_enable, got.analog_enable);
      if (got.open_drain_mask !== want.open_drain_mask)
         record_mismatch("open_drain_mask", want.open_drain_mask, got.open_drain_mask);
      if (got.pullup_mask !== want.pullup_mask)
         record_mismatch("pullup_mask", want.pullup_mask, got.pullup_mask);
      if (got.pulldown_mask !== want.pulldown_mask)
         record_mismatch("pulldown_mask", want.pulldown_mask, got.pulldown_mask);
      if (got.speed_select !== want.speed_select)
         record_mismatch("speed_select", want.speed_select, got.speed_select);
      if (got.alt_select !== want.alt_select)
         record_mismatch("alt_select", want.alt_select, got.alt_select);
      if (got.clock_enabled !== want.clock_enabled)
         record_mismatch("clock_enabled", want.clock_enabled, got.clock_enabled);
   endtask

   always @(posedge clock) begin
      gpb_pkg::rsp_type want;
      if (reset) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            mode_word[p]  = '0;
            od_word[p]    = '0;
            speed_word[p] = '0;
            pull_word[p]  = '0;
            alt_word[p]   = '0;
            out_latch[p]  = '0;
         end
         clk_on = '0;
         expected_results.delete();
      end else begin
         // take the new item first, so a same-edge result still finds its expectation
         if (req_valid && req_ready) begin
            predict_port_result(req_data, want);
            expected_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               record_mismatch("result with no item outstanding, drive_level", '0,
                               rsp_data.drive_level);
            end else begin
               want = expected_results.pop_front();
               compare_result(want, rsp_data);
            end
            results_checked++;
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

FILE: test/tb_gpio_port_bank_controller.sv
// Testbench top for the GPIO port bank controller: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_gpio_port_bank_controller;

   localparam int unsigned PORT_COUNT    = 8;
   localparam int unsigned PIN_COUNT     = 16;
   localparam logic [1:0]  OP_UNKNOWN    = 2'd3;
   localparam logic [1:0]  MODE_INPUT    = 2'd0;
   localparam logic [1:0]  PULL_NONE     = 2'd0;
   localparam logic [1:0]  PULL_RESERVED = 2'd3;
   localparam int unsigned RANDOM_ITEMS  = 1930;
   localparam int unsigned QUIET_ITEMS   = 250;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned HOLD_ITEMS    = 60;
   localparam int unsigned STALL_LIMIT   = 1000;
   localparam int unsigned DRAIN_CYCLES  = 8;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   gpb_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   gpb_pkg::rsp_type rsp_data;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned results_checked;

   bit          sender_idles   = 1'b1;
   bit          receiver_idles = 1'b1;
   bit          long_hold_due  = 1'b0;
   int unsigned sent_by_op[4];
   int unsigned rejected_items;
   int unsigned quiet_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   gpio_port_bank_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   gpb_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   function automatic gpb_pkg::req_type make_req(input logic [1:0] op, input logic [3:0] port,
                                        input logic [15:0] mask, input logic [15:0] value,
                                        input logic [4:0] pin, input logic [1:0] mode,
                                        input logic [3:0] alt_func, input logic open_drain,
                                        input logic [1:0] speed, input logic [1:0] pull,
                                        input logic [15:0] pin_levels);
      gpb_pkg::req_type r;
      r.op         = op;
      r.port       = port;
      r.mask       = mask;
      r.value      = value;
      r.pin        = pin;
      r.mode       = mode;
      r.alt_func   = alt_func;
      r.open_drain = open_drain;
      r.speed      = speed;
      r.pull       = pull;
      r.pin_levels = pin_levels;
      return r;
   endfunction

   // Mostly valid ports and pins, so that configured state builds up and gets read back
   function automatic gpb_pkg::req_type random_port_request();
      gpb_pkg::req_type r;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         r.op = gpb_pkg::OP_WRITE;
      else if (pick < 60)
         r.op = gpb_pkg::OP_READ;
      else if (pick < 95)
         r.op = gpb_pkg::OP_CONFIG;
      else
         r.op = OP_UNKNOWN;
      r.port       = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(PORT_COUNT, 15))
                                                 : 4'($urandom_range(0, PORT_COUNT - 1));
      r.pin        = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(PIN_COUNT, 31))
                                                 : 5'($urandom_range(0, PIN_COUNT - 1));
      r.mask       = 16'($urandom);
      r.value      = 16'($urandom);
      r.mode       = 2'($urandom_range(0, 3));
      r.alt_func   = 4'($urandom_range(0, 15));
      r.open_drain = 1'($urandom_range(0, 1));
      r.speed      = 2'($urandom_range(0, 3));
      r.pull       = 2'($urandom_range(0, 3));
      r.pin_levels = 16'($urandom);
      return r;
   endfunction

   // Offer one item, hold it until accepted, then maybe leave a gap
   task automatic send_item(input gpb_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      sent_by_op[r.op]++;
      if (r.port >= PORT_COUNT || r.op == OP_UNKNOWN
          || (r.op == gpb_pkg::OP_CONFIG && r.pin >= PIN_COUNT))
         rejected_items++;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Result side: random stalls, plus the long hold-off when asked for
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("FAIL gpio_port_bank_controller");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit in_hold;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, latch extremes, every mode and pull, bad ports, pins and ops
      send_item(make_req(gpb_pkg::OP_READ, 0, 16'h0000, 16'h0000, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 16'hffff));
      send_item(make_req(gpb_pkg::OP_WRITE, 0, 16'hffff, 16'hffff, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 0));
      send_item(make_req(gpb_pkg::OP_WRITE, 0, 16'h00ff, 16'h0f0f, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 0));
      send_item(make_req(gpb_pkg::OP_WRITE, 7, 16'hffff, 16'h0000, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 0));
      send_item(make_req(gpb_pkg::OP_WRITE, 7, 16'h0000, 16'hffff, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 0));
      send_item(make_req(gpb_pkg::OP_READ, 7, 16'hffff, 16'hffff, 31,
                         gpb_pkg::MODE_ANALOG, 15, 1, 3, PULL_RESERVED, 16'h0000));
      send_item(make_req(gpb_pkg::OP_READ, 3, 16'h0000, 16'h0000, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 16'ha5a5));
      send_item(make_req(gpb_pkg::OP_CONFIG, 0, 16'h0000, 16'h0000, 0,
                         gpb_pkg::MODE_OUTPUT, 15, 1, 3, gpb_pkg::PULL_UP, 16'h0000));
      send_item(make_req(gpb_pkg::OP_CONFIG, 0, 16'h0000, 16'h0000, 15,
                         gpb_pkg::MODE_ANALOG, 0, 0, 0, gpb_pkg::PULL_DOWN, 16'h0000));
      send_item(make_req(gpb_pkg::OP_CONFIG, 7, 16'h0000, 16'h0000, 15,
                         gpb_pkg::MODE_ALT, 15, 1, 3, PULL_RESERVED, 16'h0000));
      send_item(make_req(gpb_pkg::OP_CONFIG, 7, 16'h0000, 16'h0000, 15,
                         MODE_INPUT, 5, 0, 1, PULL_NONE, 16'h0000));
      send_item(make_req(gpb_pkg::OP_CONFIG, 3, 16'h0000, 16'h0000, 7,
                         gpb_pkg::MODE_ALT, 10, 1, 2, gpb_pkg::PULL_UP, 16'h0000));
      send_item(make_req(gpb_pkg::OP_CONFIG, 2, 16'h0000, 16'h0000, 16,
                         gpb_pkg::MODE_OUTPUT, 3, 1, 2, gpb_pkg::PULL_UP, 16'h0000));
      send_item(make_req(gpb_pkg::OP_CONFIG, 2, 16'h0000, 16'h0000, 31,
                         gpb_pkg::MODE_ANALOG, 15, 1, 3, gpb_pkg::PULL_DOWN, 16'h0000));
      send_item(make_req(gpb_pkg::OP_WRITE, 8, 16'hffff, 16'hffff, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 0));
      send_item(make_req(gpb_pkg::OP_READ, 15, 16'h0000, 16'h0000, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 16'hffff));
      send_item(make_req(gpb_pkg::OP_CONFIG, 15, 16'h0000, 16'h0000, 0,
                         gpb_pkg::MODE_OUTPUT, 1, 1, 1, gpb_pkg::PULL_UP, 16'h0000));
      send_item(make_req(OP_UNKNOWN, 0, 16'hffff, 16'h0000, 3,
                         gpb_pkg::MODE_OUTPUT, 2, 1, 1, gpb_pkg::PULL_UP, 16'hffff));
      send_item(make_req(OP_UNKNOWN, 12, 16'hffff, 16'hffff, 3,
                         gpb_pkg::MODE_OUTPUT, 2, 1, 1, gpb_pkg::PULL_UP, 16'hffff));
      send_item(make_req(gpb_pkg::OP_READ, 0, 16'h0000, 16'h0000, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 16'h0000));
      send_item(make_req(gpb_pkg::OP_READ, 7, 16'h0000, 16'h0000, 0,
                         MODE_INPUT, 0, 0, 0, PULL_NONE, 16'h5a5a));

      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         in_hold = (i >= 500 && i < 500 + HOLD_ITEMS) || (i >= 1200 && i < 1200 + HOLD_ITEMS);
         if (i == 500 || i == 1200)
            long_hold_due = 1'b1;
         // alternate stretches with and without gaps; none at all near the end
         sender_idles   = (i < RANDOM_ITEMS - QUIET_ITEMS) && ((i / 150) % 2 == 0) && !in_hold;
         receiver_idles = (i < RANDOM_ITEMS - QUIET_ITEMS) && ((i / 110) % 3 != 2);
         send_item(random_port_request());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d writes, %0d reads, %0d pin configs, %0d unknown ops;",
               sent_by_op[gpb_pkg::OP_WRITE], sent_by_op[gpb_pkg::OP_READ],
               sent_by_op[gpb_pkg::OP_CONFIG], sent_by_op[OP_UNKNOWN]);
      $display("%0d items were invalid, %0d results checked, %0d mismatches",
               rejected_items, results_checked, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS gpio_port_bank_controller");
      end else begin
         $display("FAIL gpio_port_bank_controller");
      end
      $finish;
   end

endmodule
